>>> hdl/bitmap_id_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap identifier allocator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_UNIT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define BIA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BIA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

>>> hdl/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap identifier allocator package
// Field widths, operation codes and status codes shared by the interface, splitter, allocator and testbench.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;

  // Shift of the fixed-point reciprocal used to split an identifier.
  localparam int unsigned DIV_SHIFT = 24;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_IGNORED = 2'd3;

endpackage

>>> hdl/bia_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap identifier allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bia_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [bia_pkg::ID_W-1:0]  release_id;

  modport source (output valid, output operation, output release_id, input ready);
  modport sink   (input valid, input operation, input release_id, output ready);
endinterface

interface bia_out_if;
  logic                          valid;
  logic                          ready;
  logic [bia_pkg::ID_W-1:0]      granted_id;
  logic [bia_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

>>> hdl/bia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bia_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest clear bit finder
// Flags a full word and locates its lowest clear bit as a one-hot mask and index.
// ----------------------------------------------------------------------------
module bia_find #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word_i,
  output logic                         full_o,
  output logic [WORD_BITS-1:0]         onehot_o,
  output logic [$clog2(WORD_BITS)-1:0] idx_o
);

  localparam int unsigned BIT_W = $clog2(WORD_BITS);

  // Adding one ripples through the trailing ones and lands on the lowest zero.
  assign full_o   = &word_i;
  assign onehot_o = ~word_i & (word_i + WORD_BITS'(1));

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot_o[i]) begin
        idx_o = idx_o | BIT_W'(i);
      end
    end
  end

endmodule

>>> hdl/bia_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier splitter
// Two-stage divide of an identifier by the word size into word and bit index.
// ----------------------------------------------------------------------------
module bia_split #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bia_pkg::ID_W-1:0]     id_i,
  output logic                         done_o,
  output logic [bia_pkg::ID_W-1:0]     word_o,
  output logic [$clog2(WORD_BITS)-1:0] bit_o
);

  localparam int unsigned BIT_W    = $clog2(WORD_BITS);
  localparam int unsigned DIV_MULT = (1 << bia_pkg::DIV_SHIFT) / WORD_BITS;
  localparam int unsigned PROD_W   = 40;

  logic                       stage1_q;
  logic                       done_q;
  logic [bia_pkg::ID_W-1:0]   id_q;
  logic [bia_pkg::ID_W-1:0]   quot_q;
  logic [bia_pkg::ID_W-1:0]   word_q;
  logic [BIT_W-1:0]           bit_q;
  logic [PROD_W-1:0]          prod;
  logic [31:0]                back;
  logic [31:0]                rem;

  // The truncated reciprocal undershoots the quotient by at most one.
  assign prod = PROD_W'(id_i) * PROD_W'(DIV_MULT);
  assign back = 32'(quot_q) * 32'(WORD_BITS);
  assign rem  = 32'(id_q) - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= start_i;
      done_q   <= stage1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      id_q   <= id_i;
      quot_q <= prod[bia_pkg::DIV_SHIFT +: bia_pkg::ID_W];
    end
    if (stage1_q) begin
      if (rem >= 32'(WORD_BITS)) begin
        word_q <= quot_q + bia_pkg::ID_W'(1);
        bit_q  <= BIT_W'(rem - 32'(WORD_BITS));
      end else begin
        word_q <= quot_q;
        bit_q  <= BIT_W'(rem);
      end
    end
  end

  assign done_o = done_q;
  assign word_o = word_q;
  assign bit_o  = bit_q;

endmodule

>>> hdl/bitmap_id_allocator_unit.sv
// Allocate: the hint word is read and checked, and each full word skipped adds a
// read of the next word, up to WORD_COUNT words in all; the bitmap RAM read port
// scans one word per cycle. Release: two-stage divide, read, write back;
// a release of identifier zero answers without them. One item is in work at a time.
// After reset the bitmap is swept clear, one word a cycle, before the first item
// is accepted.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap identifier allocator
// Next-fit allocator of 16-bit identifiers over a bitmap held in a RAM.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_unit_macros.svh"

module bitmap_id_allocator_unit #(
  parameter int unsigned WORD_COUNT = 1024,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bia_in_if.sink     req_i,
  bia_out_if.source  rsp_o
);

  localparam int unsigned ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(WORD_COUNT + 1);
  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned ID_W   = bia_pkg::ID_W;
  localparam int unsigned ST_W   = bia_pkg::STATUS_W;

  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(WORD_COUNT - 1);
  localparam logic [CNT_W-1:0]     LAST_CNT  = CNT_W'(WORD_COUNT - 1);
  localparam logic [WORD_BITS-1:0] ONE_WORD  = WORD_BITS'(1);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ACHK = 3'd2;
  localparam logic [2:0] ST_RDIV = 3'd3;
  localparam logic [2:0] ST_RWR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;

  logic                 accept;
  logic [ADDR_W-1:0]    addr_next;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 word_full;
  logic [WORD_BITS-1:0] free_onehot;
  logic [BIT_W-1:0]     free_idx;
  logic                 split_start;
  logic                 split_done;
  logic [ID_W-1:0]      split_word;
  logic [BIT_W-1:0]     split_bit;
  logic [31:0]          grant_id;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign addr_next   = (addr_q == LAST_ADDR) ? '0 : addr_q + ADDR_W'(1);
  assign grant_id    = 32'(addr_q) * 32'(WORD_BITS) + 32'(free_idx);

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bia_find #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .word_i   (ram_rdata),
    .full_o   (word_full),
    .onehot_o (free_onehot),
    .idx_o    (free_idx)
  );

  bia_split #(
    .WORD_BITS (WORD_BITS)
  ) u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (split_start),
    .id_i    (req_i.release_id),
    .done_o  (split_done),
    .word_o  (split_word),
    .bit_o   (split_bit)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    addr_d       = addr_q;
    hint_d       = hint_q;
    cnt_d        = cnt_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = addr_q;
    split_start  = 1'b0;

    case (state_q)
      ST_INIT: begin
        // Word zero keeps its lowest bit set so identifier zero is never granted.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? ONE_WORD : '0;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.operation == bia_pkg::OP_ALLOC) begin
            ram_re    = 1'b1;
            ram_raddr = hint_q;
            addr_d    = hint_q;
            cnt_d     = '0;
            state_d   = ST_ACHK;
          end else if (req_i.release_id == '0) begin
            res_id_d     = '0;
            res_status_d = bia_pkg::STATUS_ZERO_IGNORED;
            state_d      = ST_DONE;
          end else begin
            split_start = 1'b1;
            state_d     = ST_RDIV;
          end
        end
      end
      ST_ACHK: begin
        if (!word_full) begin
          ram_we       = 1'b1;
          ram_waddr    = addr_q;
          ram_wdata    = ram_rdata | free_onehot;
          hint_d       = addr_q;
          res_id_d     = ID_W'(grant_id);
          res_status_d = bia_pkg::STATUS_GRANTED;
          state_d      = ST_DONE;
        end else if (cnt_q == LAST_CNT) begin
          res_id_d     = '0;
          res_status_d = bia_pkg::STATUS_EXHAUSTED;
          state_d      = ST_DONE;
        end else begin
          // Full word: fetch the next one, wrapping at the end of the bitmap.
          cnt_d     = cnt_q + CNT_W'(1);
          addr_d    = addr_next;
          ram_re    = 1'b1;
          ram_raddr = addr_next;
        end
      end
      ST_RDIV: begin
        if (split_done) begin
          if ({1'b0, split_word} < (ID_W + 1)'(WORD_COUNT)) begin
            ram_re    = 1'b1;
            ram_raddr = split_word[ADDR_W-1:0];
            addr_d    = split_word[ADDR_W-1:0];
            state_d   = ST_RWR;
          end else begin
            res_id_d     = '0;
            res_status_d = bia_pkg::STATUS_RELEASED;
            state_d      = ST_DONE;
          end
        end
      end
      ST_RWR: begin
        ram_we       = 1'b1;
        ram_waddr    = addr_q;
        ram_wdata    = ram_rdata & ~(ONE_WORD << split_bit);
        res_id_d     = '0;
        res_status_d = bia_pkg::STATUS_RELEASED;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_id_d     = res_id_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      addr_q      <= '0;
      hint_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      addr_q      <= addr_d;
      hint_q      <= hint_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.granted_id = out_id_q;
  assign rsp_o.status     = out_status_q;

  `BIA_ASSERT_NEVER(a_ram_no_overlap, clk_i, rst_ni, ram_we && ram_re, "RAM read and write overlap")
  `BIA_ASSERT_IMPLIES(a_grant_nonzero, clk_i, rst_ni, rsp_o.valid && rsp_o.status == bia_pkg::STATUS_GRANTED, rsp_o.granted_id != '0)
  `BIA_ASSERT_IMPLIES(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `BIA_ASSERT_NEVER(a_hint_range, clk_i, rst_ni, hint_q > LAST_ADDR, "hint word out of range")

endmodule

>>> tb/sv/bitmap_id_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap identifier allocator testbench
// Runs a short table of directed requests, then random allocate and release
// traffic. A next-fit predictor in the bench supplies the expected grant and
// status of requests with no typed result; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_unit_tb;
  import bia_pkg::*;

  localparam int unsigned WORD_COUNT     = 1024;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned WORD_AW        = $clog2(WORD_COUNT);
  localparam int unsigned BIT_AW         = $clog2(WORD_BITS);
  localparam int unsigned ID_SPACE       = WORD_COUNT * WORD_BITS;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned SCRIPT_ROWS    = 20;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } id_result_t;

  typedef struct packed {
    logic                op;
    logic [ID_W-1:0]     release_id;
    logic                fixed;
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } script_row_t;

  // Rows with fixed set carry the result typed in; the others use the predictor.
  script_row_t script [SCRIPT_ROWS] = '{
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd1, STATUS_GRANTED},
    '{OP_ALLOC,   16'hFFFF, 1'b1, 16'd2, STATUS_GRANTED},
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd3, STATUS_GRANTED},
    '{OP_RELEASE, 16'h0000, 1'b1, 16'd0, STATUS_ZERO_IGNORED},
    '{OP_RELEASE, 16'h0002, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_ALLOC,   16'h1234, 1'b1, 16'd2, STATUS_GRANTED},
    '{OP_RELEASE, 16'hFFFF, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_RELEASE, 16'h0003, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_RELEASE, 16'h0003, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_RELEASE, 16'h8000, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_RELEASE, 16'h5555, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_RELEASE, 16'hAAAA, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_ALLOC,   16'h0000, 1'b1, 16'd3, STATUS_GRANTED},
    '{OP_RELEASE, 16'h0001, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_ALLOC,   16'hAAAA, 1'b1, 16'd1, STATUS_GRANTED},
    '{OP_RELEASE, 16'h0040, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_ALLOC,   16'h5555, 1'b0, 16'd0, STATUS_GRANTED},
    '{OP_ALLOC,   16'h0000, 1'b0, 16'd0, STATUS_GRANTED},
    '{OP_RELEASE, 16'h003F, 1'b1, 16'd0, STATUS_RELEASED},
    '{OP_ALLOC,   16'h8000, 1'b0, 16'd0, STATUS_GRANTED}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bia_in_if  req_if ();
  bia_out_if rsp_if ();

  bitmap_id_allocator_unit #(
    .WORD_COUNT(WORD_COUNT),
    .WORD_BITS (WORD_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: one bit per identifier and the word of the last grant.
  logic [WORD_BITS-1:0] id_map [WORD_COUNT];
  logic [WORD_AW-1:0]   last_word;

  id_result_t  pending_results [$];
  id_result_t  due_result;
  int unsigned failures;
  int unsigned idle_cycles;
  int unsigned idle_pct;
  bit          long_gaps;
  bit          hold_request;
  int unsigned rsp_stall_left;

  function automatic id_result_t predict_request(input logic op,
                                                 input logic [ID_W-1:0] rid);
    id_result_t         res;
    logic [WORD_AW-1:0] w;
    int unsigned        b;
    res.granted_id = '0;
    res.status     = STATUS_EXHAUSTED;
    if (op == OP_ALLOC) begin
      for (int n = 0; n < WORD_COUNT; n++) begin
        w = last_word + WORD_AW'(n);
        if (&id_map[w]) continue;
        b = 0;
        while (id_map[w][b]) b++;
        id_map[w][b] = 1'b1;
        // Identifier zero stays reserved: its bit is set and the scan goes on.
        if (w == 0 && b == 0) continue;
        last_word      = w;
        res.granted_id = ID_W'({w, BIT_AW'(b)});
        res.status     = STATUS_GRANTED;
        return res;
      end
      return res;
    end
    if (rid == '0) begin
      res.status = STATUS_ZERO_IGNORED;
      return res;
    end
    if (rid < ID_SPACE) begin
      id_map[rid / WORD_BITS][rid % WORD_BITS] = 1'b0;
    end
    res.status = STATUS_RELEASED;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    if (long_gaps && $urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic issue(input logic op, input logic [ID_W-1:0] rid, input logic fixed,
                       input id_result_t fixed_res, output id_result_t res);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? gap_length() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.release_id <= rid;
    do @(posedge clk_i); while (!req_if.ready);
    res = predict_request(op, rid);
    pending_results.push_back(fixed ? fixed_res : res);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string field, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
    failures++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_if.ready <= 1'b0;
    rsp_stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        rsp_stall_left = HOLD_CYCLES;
        hold_request   = 1'b0;
      end else if (rsp_stall_left == 0 && $urandom_range(99) < idle_pct) begin
        rsp_stall_left = gap_length();
      end
      if (rsp_stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t ns: result with nothing expected, granted_id %0d status %0d",
                 $time, rsp_if.granted_id, rsp_if.status);
      end else begin
        due_result = pending_results.pop_front();
        if (rsp_if.granted_id !== due_result.granted_id)
          note_mismatch("granted_id", due_result.granted_id, rsp_if.granted_id);
        if (rsp_if.status !== due_result.status)
          note_mismatch("status", ID_W'(due_result.status), ID_W'(rsp_if.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    id_result_t      got;
    id_result_t      row_res;
    logic [ID_W-1:0] rid;
    logic [ID_W-1:0] held_ids [$];
    int              hits [$];
    int unsigned     pick;
    int unsigned     slot;

    for (int w = 0; w < WORD_COUNT; w++) id_map[w] = '0;
    id_map[0][0]   = 1'b1;
    last_word      = '0;
    failures       = 0;
    idle_cycles    = 0;
    idle_pct       = 30;
    long_gaps      = 1'b1;
    hold_request   = 1'b0;

    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_ALLOC;
    req_if.release_id <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      row_res.granted_id = script[r].granted_id;
      row_res.status     = script[r].status;
      issue(script[r].op, script[r].release_id, script[r].fixed, row_res, got);
    end

    // Mostly well-formed traffic: most releases pick identifiers that are held.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) idle_pct = ((i / 100) % 4 == 3) ? 0 : 30;
      if (i == 600) hold_request = 1'b1;
      if (i == 900) wait_drained();
      pick = $urandom_range(99);
      if (pick < 55 || held_ids.size() == 0) begin
        issue(OP_ALLOC, ID_W'($urandom), 1'b0, '0, got);
        if (got.status == STATUS_GRANTED) held_ids.push_back(got.granted_id);
      end else if (pick < 88) begin
        slot = $urandom_range(held_ids.size() - 1);
        rid  = held_ids[slot];
        held_ids.delete(slot);
        issue(OP_RELEASE, rid, 1'b0, '0, got);
      end else begin
        case ($urandom_range(3))
          0:       rid = '0;
          1:       rid = '1;
          default: rid = ID_W'($urandom);
        endcase
        hits = held_ids.find_first_index(x) with (x == rid);
        if (hits.size() != 0) held_ids.delete(hits[0]);
        issue(OP_RELEASE, rid, 1'b0, '0, got);
      end
    end
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
